### sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared types for the positional array list
// Opcodes, status codes, controller states and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} pal_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} pal_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_UP_CHK,
		S_UP_WR,
		S_INS_WR,
		S_DN_CHK,
		S_DN_WR,
		S_RD,
		S_FINISH
	} pal_state_t;

	// RAM address sources
	typedef enum logic [1:0] {
		AS_K    = 2'd0,
		AS_KM1  = 2'd1,
		AS_PIDX = 2'd2
	} pal_asel_t;

	typedef struct packed {
		logic      latch;    // capture request payload
		logic      decide;   // register status, seed shift index
		logic      k_dec;
		logic      k_inc;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      ram_re;
		pal_asel_t ra_sel;
		logic      ram_we;
		pal_asel_t wa_sel;
		logic      wd_val;   // write request value, else shifted entry
		logic      load_out; // load result register
	} pal_cmd_t;

	typedef struct packed {
		pal_op_t     op;
		pal_status_t code;
		logic        k_at_pidx;
		logic        k_at_count;
		logic        out_free;
	} pal_sts_t;

endpackage

### sv/pal_req_if.sv
// ----------------------------------------------------------------------------
// pal_req_if: request channel
// One list operation per transfer: opcode, position and value.
// ----------------------------------------------------------------------------
interface pal_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [6:0]         position;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output position, output value,
		input ready);
	modport sink (input valid, input opcode, input position, input value,
		output ready);
endinterface

### sv/pal_rsp_if.sv
// ----------------------------------------------------------------------------
// pal_rsp_if: response channel
// One result per request: status, read data and list length.
// ----------------------------------------------------------------------------
interface pal_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [6:0]         list_length;

	modport source (output valid, output status, output read_value,
		output list_length, input ready);
	modport sink (input valid, input status, input read_value,
		input list_length, output ready);
endinterface

### sv/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl: list operation sequencer
// Accepts a request, checks it, steps the entry shift one RAM word at a time
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module pal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pal_pkg::pal_sts_t sts,
	output pal_pkg::pal_cmd_t cmd
);

	pal_pkg::pal_state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pal_pkg::S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		cmd       = '0;
		cmd.ra_sel = pal_pkg::AS_K;
		cmd.wa_sel = pal_pkg::AS_K;
		req_ready = 1'b0;
		unique case (st_q)
			pal_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					st_d      = pal_pkg::S_DECIDE;
				end
			end
			pal_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.code != pal_pkg::ST_OK) begin
					st_d = pal_pkg::S_FINISH;
				end else begin
					unique case (sts.op)
						pal_pkg::OP_INSERT: st_d = pal_pkg::S_UP_CHK;
						pal_pkg::OP_DELETE: st_d = pal_pkg::S_DN_CHK;
						pal_pkg::OP_READ:   st_d = pal_pkg::S_RD;
						default:            st_d = pal_pkg::S_FINISH;
					endcase
				end
			end
			pal_pkg::S_UP_CHK: begin
				if (sts.k_at_pidx) begin
					st_d = pal_pkg::S_INS_WR;
				end else begin
					cmd.ram_re = 1'b1;
					cmd.ra_sel = pal_pkg::AS_KM1;
					st_d       = pal_pkg::S_UP_WR;
				end
			end
			pal_pkg::S_UP_WR: begin
				cmd.ram_we = 1'b1;
				cmd.wa_sel = pal_pkg::AS_K;
				cmd.k_dec  = 1'b1;
				st_d       = pal_pkg::S_UP_CHK;
			end
			pal_pkg::S_INS_WR: begin
				cmd.ram_we  = 1'b1;
				cmd.wa_sel  = pal_pkg::AS_PIDX;
				cmd.wd_val  = 1'b1;
				cmd.cnt_inc = 1'b1;
				st_d        = pal_pkg::S_FINISH;
			end
			pal_pkg::S_DN_CHK: begin
				if (sts.k_at_count) begin
					cmd.cnt_dec = 1'b1;
					st_d        = pal_pkg::S_FINISH;
				end else begin
					cmd.ram_re = 1'b1;
					cmd.ra_sel = pal_pkg::AS_K;
					st_d       = pal_pkg::S_DN_WR;
				end
			end
			pal_pkg::S_DN_WR: begin
				cmd.ram_we = 1'b1;
				cmd.wa_sel = pal_pkg::AS_KM1;
				cmd.k_inc  = 1'b1;
				st_d       = pal_pkg::S_DN_CHK;
			end
			pal_pkg::S_RD: begin
				cmd.ram_re = 1'b1;
				cmd.ra_sel = pal_pkg::AS_PIDX;
				st_d       = pal_pkg::S_FINISH;
			end
			pal_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					st_d         = pal_pkg::S_IDLE;
				end
			end
			default: st_d = pal_pkg::S_IDLE;
		endcase
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result register loaded while still occupied");

	a_finish_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pal_pkg::S_FINISH && sts.out_free) |=> st_q == pal_pkg::S_IDLE)
		else $error("sequencer stuck after result handed over");

	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ram_we && cmd.ram_re))
		else $error("RAM read and write issued in the same step");

endmodule

### sv/pal_dp.sv
// ----------------------------------------------------------------------------
// pal_dp: list datapath
// Entry RAM, length count, shift index, range checks and result register.
// ----------------------------------------------------------------------------
module pal_dp #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         opcode,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	input  pal_pkg::pal_cmd_t  cmd,
	output pal_pkg::pal_sts_t  sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic signed [31:0] read_value,
	output logic [6:0]         list_length
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 7) ? CW : 7) + 1;

	pal_pkg::pal_op_t     op_q;
	logic [6:0]           pos_q;
	logic [31:0]          val_q;
	pal_pkg::pal_status_t status_q;
	pal_pkg::pal_status_t code;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        k_m1;
	logic [CW-1:0]        pidx_q;
	logic [PW-1:0]        pos_x;
	logic [PW-1:0]        cnt_x;
	logic [PW-1:0]        pos_m1;
	logic                 out_valid_q;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic [31:0]          wdata;
	logic [31:0]          rdata;

	assign pos_x  = PW'(pos_q);
	assign cnt_x  = PW'(count_q);
	assign pos_m1 = pos_x - PW'(1);
	assign k_m1   = k_q - CW'(1);

	// position and capacity checks
	always_comb begin
		code = pal_pkg::ST_OK;
		case (op_q) inside
			pal_pkg::OP_INSERT: begin
				if (pos_q == 7'd0 || pos_x > cnt_x + PW'(1)) begin
					code = pal_pkg::ST_RANGE;
				end else if (cnt_x == PW'(CAPACITY)) begin
					code = pal_pkg::ST_FULL;
				end
			end
			pal_pkg::OP_DELETE, pal_pkg::OP_READ: begin
				if (pos_q == 7'd0 || pos_x > cnt_x) begin
					code = pal_pkg::ST_RANGE;
				end
			end
			default: code = pal_pkg::ST_OK;
		endcase
	end

	always_comb begin
		case (cmd.ra_sel)
			pal_pkg::AS_KM1:  raddr = k_m1[AW-1:0];
			pal_pkg::AS_PIDX: raddr = pidx_q[AW-1:0];
			default:          raddr = k_q[AW-1:0];
		endcase
		case (cmd.wa_sel)
			pal_pkg::AS_KM1:  waddr = k_m1[AW-1:0];
			pal_pkg::AS_PIDX: waddr = pidx_q[AW-1:0];
			default:          waddr = k_q[AW-1:0];
		endcase
	end

	assign wdata = cmd.wd_val ? val_q : rdata;

	pal_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// request payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= pal_pkg::pal_op_t'(opcode);
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.decide) begin
			status_q <= code;
			pidx_q   <= pos_m1[CW-1:0];
			if (op_q == pal_pkg::OP_INSERT) begin
				k_q <= count_q;
			end else begin
				k_q <= pos_x[CW-1:0];
			end
		end else if (cmd.k_dec) begin
			k_q <= k_m1;
		end else if (cmd.k_inc) begin
			k_q <= k_q + CW'(1);
		end
		if (cmd.load_out) begin
			status      <= status_q;
			read_value  <= (op_q == pal_pkg::OP_READ && status_q == pal_pkg::ST_OK)
				? rdata : 32'd0;
			list_length <= cnt_x[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.op         = op_q;
	assign sts.code       = code;
	assign sts.k_at_pidx  = (k_q == pidx_q);
	assign sts.k_at_count = (k_q == count_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("length count beyond capacity");

	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> count_q < CW'(CAPACITY))
		else $error("insert committed into a full list");

	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> count_q != '0)
		else $error("delete committed on an empty list");

endmodule

### sv/positional_array_list_unit.sv
// ----------------------------------------------------------------------------
// positional_array_list_unit: ordered list with positional insert/delete/read
// Holds up to CAPACITY signed words in RAM with a length count. Insert and
// delete move the later entries one place through the single RAM port pair.
// ----------------------------------------------------------------------------
//  channel | dir | fields                               | per transfer
//  --------+-----+--------------------------------------+------------------
//  req     | in  | opcode, position, value              | one list operation
//  rsp     | out | status, read_value, list_length      | one result
//
//  Each moved entry costs a RAM read and a RAM write.
//  Reset clears the sequencer state, length count and result valid flag;
//    RAM entries stay undefined until written. A result waits in the output
//    register; the next request is taken and worked on meanwhile and stalls
//    only at hand-over if rsp is still full.
module positional_array_list_unit #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	pal_req_if.sink         req,
	pal_rsp_if.source       rsp
);

	// command and status bundles between sequencer and datapath
	pal_pkg::pal_cmd_t cmd;
	pal_pkg::pal_sts_t sts;

	pal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pal_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (req.opcode),
		.position   (req.position),
		.value      (req.value),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.status     (rsp.status),
		.read_value (rsp.read_value),
		.list_length(rsp.list_length)
	);

endmodule
